[design/eas_pkg.sv]
// Package for the encoder angle and speed estimator.
// Holds shared constants, the controller state type and command/status structs.
// No dependencies.
package eas_pkg;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam logic [11:0] CODE_MASK = 12'hFFF;
    localparam int CODES_PER_TURN = 4096;
    localparam int HALF_CODES = 2048;
    localparam int CODE_TO_BAM_SHIFT = 20;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_POLES = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_FILT,
        ST_EXTRA,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic start_div1;
        logic start_div2;
        logic filt;
        logic extra;
        logic show;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic need_speed;
        logic out_taken;
    } sts_t;
endpackage

[design/eas_if.sv]
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing.
interface eas_if #(parameter int W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/eas_div.sv]
// Iterative signed restoring divider, one quotient bit per cycle.
// Depends on nothing.
module eas_div #(
    parameter int NW = 64,
    parameter int DW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;

    // Shift in the next numerator bit and try a subtract.
    always_comb
    begin
        trial  = {r_reg[DW-1:0], q_reg[NW-1]};
        q_next = {q_reg[NW-2:0], 1'b0};
        r_next = trial;
        if (trial >= {1'b0, d_reg})
        begin
            r_next    = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NW-1] ? NW'(-num) : num;
            neg_reg <= num[NW-1];
            r_reg   <= '0;
            d_reg   <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

[design/eas_ctrl.sv]
// Controller state machine of the estimator.
// Depends on eas_pkg.
module eas_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  eas_pkg::sts_t   sts,
    output logic            in_ready,
    output logic            out_valid,
    output eas_pkg::cmd_t   cmd
);
    eas_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= eas_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            eas_pkg::ST_IDLE:
                if (in_fire)
                    state_next = eas_pkg::ST_DIV1;
            eas_pkg::ST_DIV1:
                if (!sts.need_speed)
                    state_next = eas_pkg::ST_EXTRA;
                else if (sts.div_done)
                    state_next = eas_pkg::ST_DIV2;
            eas_pkg::ST_DIV2:
                if (sts.div_done)
                    state_next = eas_pkg::ST_FILT;
            eas_pkg::ST_FILT:
                state_next = eas_pkg::ST_EXTRA;
            eas_pkg::ST_EXTRA:
                state_next = eas_pkg::ST_OUT;
            eas_pkg::ST_OUT:
                if (sts.out_taken)
                    state_next = eas_pkg::ST_IDLE;
            default:
                state_next = eas_pkg::ST_IDLE;
        endcase
    end

    logic div1_first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div1_first_reg <= 1'b0;
        else
            div1_first_reg <= (state_reg == eas_pkg::ST_IDLE) && in_fire;
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            eas_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
            end
            eas_pkg::ST_DIV1:
                cmd.start_div1 = div1_first_reg && sts.need_speed;
            eas_pkg::ST_DIV2:
                cmd.start_div2 = 1'b0;
            eas_pkg::ST_FILT:
                cmd.filt = 1'b1;
            eas_pkg::ST_EXTRA:
                cmd.extra = 1'b1;
            eas_pkg::ST_OUT:
                out_valid = 1'b1;
            default: ;
        endcase
        cmd.start_div2 = (state_reg == eas_pkg::ST_DIV1) && sts.div_done && sts.need_speed;
        cmd.show = out_valid;
    end
endmodule

[design/eas_dp.sv]
// Datapath of the estimator: state registers, dividers, filter and extrapolation.
// Depends on eas_pkg and eas_div.
module eas_dp #(
    parameter int FRAC_BITS = eas_pkg::FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic               cfg_idx_ok,
    input  logic [31:0]        cfg_data,
    input  logic [11:0]        raw_angle,
    input  logic               magnet_ok,
    input  logic [31:0]        sample_sequence,
    input  eas_pkg::cmd_t      cmd,
    output eas_pkg::sts_t      sts,
    output logic [31:0]        angle_o,
    output logic signed [31:0] speed_o,
    output logic               status_o
);
    localparam logic signed [63:0] QONE = 64'sd1 <<< FRAC_BITS;

    logic [16:0] alpha_reg;
    logic [15:0] timeout_reg;
    logic [7:0]  poles_reg;
    logic [30:0] period_reg;

    logic [11:0] last_code_reg;
    logic [31:0] last_seq_reg;
    logic [15:0] ticks_reg;
    logic [31:0] base_reg;
    logic signed [31:0] speed_reg;
    logic init_reg, valid_reg, need_reg, stat_reg, short_reg;
    logic [11:0] code_reg;
    logic [31:0] angle_reg;
    logic signed [63:0] m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= 17'd16384;
            timeout_reg <= 16'd100;
            poles_reg   <= 8'd1;
            period_reg  <= 31'd3;
        end
        else if (cfg_we && cfg_idx_ok)
        begin
            unique case (cfg_idx)
                eas_pkg::REG_ALPHA:   alpha_reg   <= cfg_data[16:0];
                eas_pkg::REG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                eas_pkg::REG_POLES:   poles_reg   <= cfg_data[7:0];
                eas_pkg::REG_PERIOD:  period_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Wrapped code difference.
    logic signed [13:0] d0, delta;
    always_comb
    begin
        d0 = $signed({2'b00, code_reg}) - $signed({2'b00, last_code_reg});
        if (d0 > 14'sd2048)
            delta = d0 - 14'sd4096;
        else if (d0 < -14'sd2048)
            delta = d0 + 14'sd4096;
        else
            delta = d0;
    end

    // The first division is by 4096 times the tick count; its quotient feeds
    // the second division directly while its done pulse is high.
    logic               d1_done, d2_done;
    logic signed [63:0] q1, q2;
    logic signed [63:0] num1;
    assign num1 = 64'(delta) <<< FRAC_BITS;
    eas_div #(.NW(64), .DW(32)) u_div1 (
        .clk(clk), .rst_n(rst_n), .start(cmd.start_div1), .num(num1),
        .den({4'd0, ticks_reg, 12'd0}), .done(d1_done), .quo(q1)
    );
    eas_div #(.NW(64), .DW(32)) u_div2 (
        .clk(clk), .rst_n(rst_n), .start(cmd.start_div2), .num(q1 <<< FRAC_BITS),
        .den({1'b0, period_reg}), .done(d2_done), .quo(q2)
    );

    logic div2_phase_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div2_phase_reg <= 1'b0;
        else if (cmd.start_div2)
            div2_phase_reg <= 1'b1;
        else if (d2_done)
            div2_phase_reg <= 1'b0;
    end
    assign sts.div_done = div2_phase_reg ? d2_done : d1_done;
    assign sts.need_speed = need_reg;
    assign sts.out_taken = 1'b0;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Filter step, after both divisions.
    logic signed [31:0] rs, diff, stp;
    logic signed [65:0] prod;
    always_comb
    begin
        if (period_reg == 31'd0 ||
            q2 > 64'sd2147483647 || q2 < -64'sd2147483648)
            rs = '0;
        else
            rs = q2[31:0];
        diff = sat32(66'(rs) - 66'(speed_reg));
        prod = 66'(diff) * $signed({49'd0, alpha_reg});
        stp  = sat32(prod >>> FRAC_BITS);
    end

    // Extrapolation.
    logic signed [32:0] mag;
    logic signed [63:0] turns;
    logic signed [95:0] mt;
    always_comb
    begin
        mag = speed_reg[31] ? -33'(speed_reg) : 33'(speed_reg);
        mt  = 96'(m_reg) * $signed({80'd0, ticks_reg});
        if (ticks_reg == 16'd0)
            turns = '0;
        else if (m_reg > 64'sd2147483647)
            turns = 64'sd2147483647;
        else if (m_reg < -64'sd2147483648)
            turns = -64'sd2147483648;
        else
            turns = 64'(sat32(mt[65:0]));
    end

    logic signed [63:0] sp;
    assign sp = 64'(speed_reg) * $signed({33'd0, period_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_code_reg <= '0;
            last_seq_reg  <= '0;
            ticks_reg     <= '0;
            base_reg      <= '0;
            speed_reg     <= '0;
            init_reg      <= 1'b0;
            valid_reg     <= 1'b0;
            need_reg      <= 1'b0;
            stat_reg      <= 1'b0;
            short_reg     <= 1'b0;
            code_reg      <= '0;
        end
        else if (cmd.load)
        begin
            code_reg  <= raw_angle;
            need_reg  <= 1'b0;
            short_reg <= 1'b0;
            stat_reg  <= 1'b0;
            if (!magnet_ok)
            begin
                valid_reg <= 1'b0;
                stat_reg  <= 1'b1;
                short_reg <= 1'b1;
            end
            else if (sample_sequence != last_seq_reg)
            begin
                if (!init_reg || (sample_sequence - last_seq_reg) > 32'd1)
                begin
                    init_reg  <= 1'b1;
                    speed_reg <= '0;
                    base_reg  <= {raw_angle, 20'd0};
                    last_code_reg <= raw_angle;
                    ticks_reg <= '0;
                end
                else
                begin
                    need_reg <= 1'b1;
                    if (ticks_reg != 16'hFFFF)
                        ticks_reg <= ticks_reg + 1'b1;
                end
                last_seq_reg <= sample_sequence;
                valid_reg    <= 1'b1;
            end
            else
            begin
                if (ticks_reg != 16'hFFFF)
                    ticks_reg <= ticks_reg + 1'b1;
                if (((ticks_reg == 16'hFFFF) ? 17'h0FFFF : 17'(ticks_reg) + 17'd1) >
                    17'(timeout_reg))
                begin
                    valid_reg <= 1'b0;
                    stat_reg  <= 1'b1;
                end
            end
        end
        else if (cmd.filt)
        begin
            speed_reg     <= sat32(66'(speed_reg) + 66'(stp));
            base_reg      <= {code_reg, 20'd0};
            last_code_reg <= code_reg;
            ticks_reg     <= '0;
        end
    end

    // m is registered, so the extrapolation uses the value from the cycle before.
    always_ff @(posedge clk)
    begin
        m_reg <= (sp < 0) ? -((-sp) >>> FRAC_BITS) : (sp >>> FRAC_BITS);
        if (cmd.extra)
        begin
            if (short_reg || !valid_reg || poles_reg == 8'd0 ||
                $signed({31'd0, mag}) * $signed({56'd0, poles_reg}) < QONE)
                angle_reg <= base_reg;
            else
                angle_reg <= base_reg + (turns[31:0] << (32 - FRAC_BITS));
        end
    end

    assign angle_o  = angle_reg;
    assign speed_o  = speed_reg;
    assign status_o = stat_reg;
endmodule

[design/encoder_angle_speed_estimator.sv]
// Top level of the encoder angle and speed estimator.
// Depends on eas_pkg, eas_if, eas_ctrl, eas_dp and eas_div.
//
// Channel   Direction  Payload
// in_ch     sink       raw_angle[11:0], magnet_ok, sample_sequence[31:0]
// out_ch    source     mechanical_angle[31:0], mechanical_speed[31:0], status
// cfg_ch    sink       index[1:0]+spare, data[31:0]
//
// An item with a one-step sequence advance runs two 64-step serial divisions in
// sequence; other items skip them. Reset clears the controller and tracking
// state, not angle_reg, and restores the register defaults. A new input is taken
// only once the previous result transfer has completed; a stalled output holds.
module encoder_angle_speed_estimator #(
    parameter int FRAC_BITS = eas_pkg::FRAC_BITS_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    eas_if.sink   in_ch,
    eas_if.source out_ch,
    eas_if.sink   cfg_ch
);
    // Input data packing: {sample_sequence, magnet_ok, raw_angle}.
    // Output packing: {status, mechanical_speed, mechanical_angle}.
    // Config packing: {index[31:0], data[31:0]}.
    eas_pkg::cmd_t cmd;
    eas_pkg::sts_t sts_dp, sts;
    logic in_fire, out_valid, in_ready;
    logic [31:0] angle;
    logic signed [31:0] speed;
    logic status;

    assign in_fire = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;
    assign cfg_ch.ready = 1'b1;

    // Handshake completion is folded into the status struct here.
    always_comb
    begin
        sts = sts_dp;
        sts.out_taken = out_valid && out_ch.ready;
    end

    eas_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .sts(sts),
        .in_ready(in_ready), .out_valid(out_valid), .cmd(cmd)
    );

    eas_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.data[33:32]),
        .cfg_idx_ok(cfg_ch.data[63:34] == 30'd0), .cfg_data(cfg_ch.data[31:0]),
        .raw_angle(in_ch.data[11:0]), .magnet_ok(in_ch.data[12]),
        .sample_sequence(in_ch.data[44:13]),
        .cmd(cmd), .sts(sts_dp),
        .angle_o(angle), .speed_o(speed), .status_o(status)
    );

    assign out_ch.valid = out_valid;
    assign out_ch.data  = {status, speed, angle};

`ifndef SYNTHESIS
    // No input is taken while a result is pending.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    // A result follows a load only after processing.
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !out_valid) else $error("result shown too early");
    // Result payload holds while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ch.ready) |=> $stable(out_ch.data))
        else $error("result changed while stalled");
`endif
endmodule
